@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the color difference block.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, ignored while the reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Clocked check, evaluated on every edge.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLKD(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/cie76_pkg.sv @@
// Shared constants, types and elaboration-time functions for the CIE76 delta E block.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package cie76_pkg;

   localparam int unsigned CHANNEL_BITS_DEF = 8;

   // Q30 linear light, 0 .. 1.0
   localparam int unsigned LIN_W = 31;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   // sRGB to XYZ matrix, rows X, Y, Z, scaled by 1e5 (Y row by 1e4; per white divisor below)
   localparam int unsigned COEF_W = 17;
   typedef logic [COEF_W-1:0] coef_type;
   localparam coef_type MAT_COEF [3][3] = '{
      '{17'd41240, 17'd35760, 17'd18050},
      '{17'd2126,  17'd7152,  17'd722},
      '{17'd1930,  17'd11920, 17'd95050}
   };
   localparam int unsigned X_DIV = 95047;
   localparam int unsigned Y_DIV = 10000;
   localparam int unsigned Z_DIV = 108883;

   localparam int unsigned PROD_W   = LIN_W + COEF_W;
   localparam int unsigned SUM_W    = 47;
   localparam int unsigned Y_SUM_W  = 44;

   // constant divider
   localparam int unsigned RECIP_W  = 32;
   localparam int unsigned CDIV_LAT = 4;

   // Lab f()
   localparam int unsigned F_W        = 31;
   localparam int unsigned LINF_T_W   = 24;
   localparam int unsigned LINF_NUM_W = 45;
   localparam int unsigned LINF_DIV   = 116000;
   localparam int unsigned F_SLOPE    = 903292;
   localparam logic [LINF_NUM_W-1:0] F_OFFSET = LINF_NUM_W'(64'd16000 << 30);
   localparam logic [F_W-1:0] F_KNEE = F_W'((64'd8856 << 30) / 64'd1000000);
   localparam int unsigned LABF_LAT = F_W + 1;

   // distance
   localparam int unsigned DF_W       = 34;
   localparam int unsigned DIFF_SHIFT = 14;
   localparam int unsigned K_W        = 9;
   localparam logic [K_W-1:0] DIFF_K [3] = '{9'd116, 9'd500, 9'd200};
   localparam int unsigned COMP_W     = 27;
   localparam int unsigned SQ_W       = 2 * COMP_W;
   localparam int unsigned SS_W       = SQ_W + 2;
   localparam int unsigned ROOT_W     = SS_W / 2;
   localparam int unsigned DE_W       = 17;
   localparam int unsigned DE_FRAC    = 8;
   localparam int unsigned RSP_TDATA_W = 24;

   localparam int unsigned PIPE_LAT = 3 + CDIV_LAT + LABF_LAT + 4 + ROOT_W + 1;

   function automatic longint unsigned mul_q30(input longint unsigned a,
                                               input longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned fifth_root_q30(input longint unsigned t);
      longint unsigned r, c, c2, c4, c5;
      r = 0;
      for (int bp = 30; bp >= 0; bp--) begin
         c = r | (64'd1 << bp);
         if (c <= ONE_Q30) begin
            c2 = mul_q30(c, c);
            c4 = mul_q30(c2, c2);
            c5 = mul_q30(c4, c);
            if (c5 <= t) r = c;
         end
      end
      return r;
   endfunction

   // Bitwise quotient search; only evaluated while building the gamma table.
   function automatic longint unsigned quo_search(input longint unsigned n,
                                                  input longint unsigned d);
      longint unsigned q, c;
      q = 0;
      for (int bp = 32; bp >= 0; bp--) begin
         c = q | (64'd1 << bp);
         if (c * d <= n) q = c;
      end
      return q;
   endfunction

   // sRGB gamma expansion of one code, Q30
   function automatic logic [LIN_W-1:0] lin_q30(input longint unsigned v,
                                                input int unsigned bits);
      longint unsigned m, x, x2;
      m = (64'd1 << bits) - 64'd1;
      if (v * 64'd100000 > 64'd4045 * m) begin
         x  = quo_search((64'd1000 * v + 64'd55 * m) << 30, 64'd1055 * m);
         x2 = mul_q30(x, x);
         return LIN_W'(mul_q30(x2, fifth_root_q30(x2)));
      end
      return LIN_W'(quo_search((v * 64'd100) << 30, 64'd1292 * m));
   endfunction

endpackage

`default_nettype wire

@@ rtl/cie76_cdiv.sv @@
// Pipelined division of an unsigned value by a constant (reciprocal multiply, one fixup).
// Depends on cie76_pkg; registers products, estimate, check, result; advances when adv is high.
`default_nettype none

module cie76_cdiv #(
   parameter int unsigned DIVISOR = 3,
   parameter int unsigned NUM_W   = 16,
   parameter int unsigned Q_W     = 16
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   output logic [Q_W-1:0]   quo
);
   import cie76_pkg::*;

   localparam int unsigned LO_W  = NUM_W / 2;
   localparam int unsigned HI_W  = NUM_W - LO_W;
   localparam int unsigned PH_W  = HI_W + RECIP_W;
   localparam int unsigned PL_W  = LO_W + RECIP_W;
   localparam int unsigned ACC_W = NUM_W + RECIP_W + 1;
   localparam int unsigned DV_W  = $clog2(DIVISOR + 1);
   localparam int unsigned PQ_W  = Q_W + DV_W;
   // floor(2^NUM_W / D): estimate is low by at most one
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << NUM_W) / 64'(DIVISOR));

   logic [PH_W-1:0]  ph_ff, ph_in;
   logic [PL_W-1:0]  pl_ff, pl_in;
   logic [NUM_W-1:0] n1_ff, n2_ff, n3_ff;
   logic [ACC_W-1:0] acc;
   logic [Q_W-1:0]   q0_ff, q0_in, q3_ff, quo_ff, quo_in;
   logic [NUM_W-1:0] qd_ff, qd_in, rem;

   always_comb begin
      ph_in  = PH_W'(num[NUM_W-1:LO_W]) * PH_W'(RECIP);
      pl_in  = PL_W'(num[LO_W-1:0]) * PL_W'(RECIP);
      acc    = (ACC_W'(ph_ff) << LO_W) + ACC_W'(pl_ff);
      q0_in  = Q_W'(acc >> NUM_W);
      qd_in  = NUM_W'(PQ_W'(q0_ff) * PQ_W'(DIVISOR));
      rem    = n3_ff - qd_ff;
      quo_in = (rem >= NUM_W'(DIVISOR)) ? q3_ff + Q_W'(1) : q3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff  <= ph_in;
         pl_ff  <= pl_in;
         n1_ff  <= num;
         q0_ff  <= q0_in;
         n2_ff  <= n1_ff;
         qd_ff  <= qd_in;
         q3_ff  <= q0_ff;
         n3_ff  <= n2_ff;
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

@@ rtl/cie76_labf.sv @@
// CIE Lab f() on one Q30 value: pipelined cube root beside the linear segment.
// Depends on cie76_pkg and cie76_cdiv; the select of the two segments is registered.
`default_nettype none

module cie76_labf (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [cie76_pkg::F_W-1:0] t,
   output logic [cie76_pkg::F_W-1:0] f
);
   import cie76_pkg::*;

   localparam int unsigned CR_N    = F_W;
   localparam int unsigned SQ2_W   = 2 * F_W;
   localparam int unsigned C3_W    = 2 * F_W + 1;
   localparam int unsigned LIN_DLY = CR_N - 1 - CDIV_LAT;

   logic [F_W-1:0]   cr_t_ff [CR_N];
   logic [F_W-1:0]   cr_r_ff [CR_N];
   logic [SQ2_W-1:0] cr_sq_ff [CR_N-1];

   // one root bit per stage, square kept exact so only one multiply per stage
   for (genvar k = 0; k < CR_N; k++) begin : g_cr
      localparam int unsigned BI = CR_N - 1 - k;
      logic [F_W-1:0]   t_cur, r_cur, c, r_in;
      logic [SQ2_W-1:0] sq_cur, sq_c, sq_in;
      logic [C3_W-1:0]  c3;
      logic             fits;

      if (k == 0) begin : g_first
         assign t_cur  = t;
         assign r_cur  = '0;
         assign sq_cur = '0;
      end else begin : g_next
         assign t_cur  = cr_t_ff[k-1];
         assign r_cur  = cr_r_ff[k-1];
         assign sq_cur = cr_sq_ff[k-1];
      end

      always_comb begin
         c     = r_cur | (F_W'(1) << BI);
         sq_c  = sq_cur + (SQ2_W'(r_cur) << (BI + 1)) + (SQ2_W'(1) << (2 * BI));
         c3    = C3_W'(sq_c[SQ2_W-1:F_W-1]) * C3_W'(c);
         fits  = c3[C3_W-1:F_W-1] <= {2'b00, t_cur};
         r_in  = fits ? c : r_cur;
         sq_in = fits ? sq_c : sq_cur;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cr_t_ff[k] <= t_cur;
            cr_r_ff[k] <= r_in;
         end
      end

      if (k < CR_N - 1) begin : g_sq
         always_ff @(posedge clock) begin
            if (adv) begin
               cr_sq_ff[k] <= sq_in;
            end
         end
      end
   end

   // linear segment: only valid below the knee, where t fits LINF_T_W bits
   logic [LINF_NUM_W-1:0] num_ff, num_in;
   logic [F_W-1:0]        lin_q;
   logic [F_W-1:0]        lin_dly_ff [LIN_DLY];
   logic [F_W-1:0]        f_ff, f_in;

   assign num_in = LINF_NUM_W'(F_SLOPE) * LINF_NUM_W'(t[LINF_T_W-1:0]) + F_OFFSET;

   cie76_cdiv #(
      .DIVISOR (LINF_DIV),
      .NUM_W   (LINF_NUM_W),
      .Q_W     (F_W)
   ) u_lin_div (
      .clock (clock),
      .adv   (adv),
      .num   (num_ff),
      .quo   (lin_q)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff        <= num_in;
         lin_dly_ff[0] <= lin_q;
         for (int j = 1; j < LIN_DLY; j++) begin
            lin_dly_ff[j] <= lin_dly_ff[j-1];
         end
         f_ff <= f_in;
      end
   end

   assign f_in = (cr_t_ff[CR_N-1] > F_KNEE) ? cr_r_ff[CR_N-1] : lin_dly_ff[LIN_DLY-1];
   assign f    = f_ff;

endmodule

`default_nettype wire

@@ rtl/cie76_color_difference.sv @@
// CIE76 delta E between two sRGB colors: one transaction in, one result out.
// Depends on cie76_pkg, cie76_cdiv, cie76_labf and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block takes a pair of sRGB colors per transaction and returns their CIE76
// Lab distance as an unsigned number with 8 fraction bits, saturating at 131071.
// It accepts one transaction every clock cycle while the output is not stalled.
// The latency is set mostly by the cube-root recurrence of Lab f() (one root
// bit per stage, 31 stages plus a select) and the digit-by-digit square root of
// the distance (28 stages). When the result at the output is not taken, the
// whole pipeline holds; nothing is dropped or duplicated. The block keeps no
// state between transactions.

module cie76_color_difference #(
   parameter int unsigned CHANNEL_BITS = cie76_pkg::CHANNEL_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_red, first_green, first_blue, second_red, second_green, second_blue
   input  logic [((6 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // delta_e [16:0], zero fill above
   output logic [cie76_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cie76_pkg::*;

   localparam int unsigned LIN_DEPTH = 2 ** CHANNEL_BITS;
   localparam int unsigned SCL_W     = DF_W + K_W;
   localparam int unsigned DL_W      = SS_W + 1;

   // Pipeline control: every stage advances together when the output can move.
   logic                adv;
   logic [PIPE_LAT:1]   vld_ff, vld_in;

   assign adv        = !vld_ff[PIPE_LAT] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PIPE_LAT];
   assign vld_in     = {vld_ff[PIPE_LAT-1:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Gamma expansion table, computed at elaboration.
   logic [LIN_W-1:0] lin_rom [LIN_DEPTH];

   for (genvar i = 0; i < LIN_DEPTH; i++) begin : g_lin
      localparam logic [LIN_W-1:0] LIN_VAL = lin_q30(64'(i), CHANNEL_BITS);
      assign lin_rom[i] = LIN_VAL;
   end

   // Stage 1: unpack the six channels and look them up.
   logic [CHANNEL_BITS-1:0] chan [6];
   logic [LIN_W-1:0]        lin_ff [6], lin_in [6];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         chan[k]   = req_tdata[k*CHANNEL_BITS +: CHANNEL_BITS];
         lin_in[k] = lin_rom[chan[k]];
      end
   end

   // Stage 2: matrix products. Stage 3: row sums.
   logic [PROD_W-1:0] prod_ff [2][3][3], prod_in [2][3][3];
   logic [SUM_W-1:0]  sum_ff [2][3], sum_in [2][3];

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               prod_in[c][r][j] = PROD_W'(lin_ff[c*3+j]) * PROD_W'(MAT_COEF[r][j]);
            end
            sum_in[c][r] = SUM_W'(prod_ff[c][r][0] + prod_ff[c][r][1] + prod_ff[c][r][2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff  <= lin_in;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   // White normalization (divide by the D65 white) and Lab f() per component.
   logic [F_W-1:0] xyz_w [2][3];
   logic [F_W-1:0] f_w [2][3];

   for (genvar c = 0; c < 2; c++) begin : g_col
      cie76_cdiv #(.DIVISOR(X_DIV), .NUM_W(SUM_W), .Q_W(F_W)) u_xdiv (
         .clock (clock),
         .adv   (adv),
         .num   (sum_ff[c][0]),
         .quo   (xyz_w[c][0])
      );
      cie76_cdiv #(.DIVISOR(Y_DIV), .NUM_W(Y_SUM_W), .Q_W(F_W)) u_ydiv (
         .clock (clock),
         .adv   (adv),
         .num   (sum_ff[c][1][Y_SUM_W-1:0]),
         .quo   (xyz_w[c][1])
      );
      cie76_cdiv #(.DIVISOR(Z_DIV), .NUM_W(SUM_W), .Q_W(F_W)) u_zdiv (
         .clock (clock),
         .adv   (adv),
         .num   (sum_ff[c][2]),
         .quo   (xyz_w[c][2])
      );
      for (genvar r = 0; r < 3; r++) begin : g_comp
         cie76_labf u_labf (
            .clock (clock),
            .adv   (adv),
            .t     (xyz_w[c][r]),
            .f     (f_w[c][r])
         );
      end
   end

   // D1: signed L, a, b differences. D2: magnitude times weight, Q16.
   // D3: squares. D4: sum of squares.
   logic signed [DF_W-1:0] fs [2][3];
   logic signed [DF_W-1:0] dif_ff [3], dif_in [3];
   logic [DF_W-1:0]        mag [3];
   logic [COMP_W-1:0]      cmp_ff [3], cmp_in [3];
   logic [SQ_W-1:0]        sq_ff [3], sq_in [3];
   logic [SS_W-1:0]        ss_ff, ss_in;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         for (int r = 0; r < 3; r++) begin
            fs[c][r] = $signed({3'b000, f_w[c][r]});
         end
      end
      dif_in[0] = fs[0][1] - fs[1][1];
      dif_in[1] = (fs[0][0] - fs[0][1]) - (fs[1][0] - fs[1][1]);
      dif_in[2] = (fs[0][1] - fs[0][2]) - (fs[1][1] - fs[1][2]);
      for (int i = 0; i < 3; i++) begin
         mag[i]    = dif_ff[i][DF_W-1] ? DF_W'(-dif_ff[i]) : DF_W'(dif_ff[i]);
         cmp_in[i] = COMP_W'((SCL_W'(mag[i]) * SCL_W'(DIFF_K[i])) >> DIFF_SHIFT);
         sq_in[i]  = SQ_W'(cmp_ff[i]) * SQ_W'(cmp_ff[i]);
      end
      ss_in = SS_W'(sq_ff[0]) + SS_W'(sq_ff[1]) + SS_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dif_ff <= dif_in;
         cmp_ff <= cmp_in;
         sq_ff  <= sq_in;
         ss_ff  <= ss_in;
      end
   end

   // Square root, one result bit per stage: keep root and remainder n - root^2.
   logic [SS_W-1:0]   rem_ff [ROOT_W-1];
   logic [ROOT_W-1:0] rt_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int unsigned BI = ROOT_W - 1 - k;
      logic [SS_W-1:0]   rem_cur, rem_in;
      logic [ROOT_W-1:0] rt_cur, rt_in;
      logic [DL_W-1:0]   delta;

      if (k == 0) begin : g_first
         assign rem_cur = ss_ff;
         assign rt_cur  = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign rt_cur  = rt_ff[k-1];
      end

      always_comb begin
         delta = (DL_W'(rt_cur) << (BI + 1)) + (DL_W'(1) << (2 * BI));
         if ({1'b0, rem_cur} >= delta) begin
            rem_in = SS_W'({1'b0, rem_cur} - delta);
            rt_in  = rt_cur | (ROOT_W'(1) << BI);
         end else begin
            rem_in = rem_cur;
            rt_in  = rt_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_ff[k] <= rt_in;
         end
      end

      if (k < ROOT_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   // Output register: drop the fraction bits below Q8 and saturate.
   logic [DE_W-1:0]   de_ff, de_in;
   logic [ROOT_W-1:0] root;

   assign root  = rt_ff[ROOT_W-1];
   assign de_in = (|root[ROOT_W-1:DE_W+DE_FRAC]) ? '1 : root[DE_W+DE_FRAC-1:DE_FRAC];

   always_ff @(posedge clock) begin
      if (adv) begin
         de_ff <= de_in;
      end
   end

   assign rsp_tdata = {{(RSP_TDATA_W - DE_W){1'b0}}, de_ff};

   // A stalled pipeline must hold its occupancy; an accepted transaction
   // must enter the first stage; reset must empty the output.
   `ASSERT_CLKD(a_stall_holds, clock, reset, !adv |=> $stable(vld_ff))
   `ASSERT_CLKD(a_accept_enters, clock, reset, adv && req_tvalid |=> vld_ff[1])
   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid)

endmodule

`default_nettype wire

@@ tb/cie76_color_difference_tb.sv @@
// Testbench for cie76_color_difference: drives sRGB color pairs and checks delta E.
// Depends on cie76_pkg and the RTL of the block; the predictor is self-contained.
`timescale 1ns / 100ps
`default_nettype none

module cie76_color_difference_tb;
   import cie76_pkg::*;

   localparam int unsigned CB = 8;
   localparam int unsigned REQ_W = ((6 * CB + 7) / 8) * 8;
   localparam int unsigned DE_LIMIT = 131071;
   localparam int unsigned N_RANDOM = 1880;
   localparam int unsigned EXP_DEPTH = 4096;

   typedef struct packed {
      logic [7:0] second_blue;
      logic [7:0] second_green;
      logic [7:0] second_red;
      logic [7:0] first_blue;
      logic [7:0] first_green;
      logic [7:0] first_red;
   } color_pair_type;

   typedef struct {
      color_pair_type pair;
      logic           known;   // expected value typed in below
      logic [16:0]    de;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // expected results in send order; written at the tail, read at the head
   logic [16:0] exp_fifo [EXP_DEPTH];
   int unsigned exp_wr = 0;
   int unsigned exp_rd = 0;
   int unsigned fail_count = 0;
   int unsigned rsp_count = 0;
   int unsigned tx_idle_pct = 6;
   int unsigned rx_idle_pct = 86;
   logic        rx_hold = 1'b0;
   logic        stim_done = 1'b0;

   cie76_color_difference #(.CHANNEL_BITS(CB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // ---------------- delta E predictor (Q30 fixed point throughout) -------------
   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned gamma_expand(longint unsigned v);
      longint unsigned m, x, x2, r, c;
      m = (64'd1 << CB) - 1;
      v = v & m;
      if (v * 100000 > 4045 * m) begin
         x  = ((1000 * v + 55 * m) << 30) / (1055 * m);
         x2 = q30_mul(x, x);
         r  = 0;
         // largest r <= 1.0 with r^5 <= x2
         for (int b = 30; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c <= (64'd1 << 30) &&
                q30_mul(q30_mul(q30_mul(c, c), q30_mul(c, c)), c) <= x2) r = c;
         end
         return q30_mul(x2, r);
      end
      return ((v * 100) << 30) / (1292 * m);
   endfunction

   function automatic longint unsigned lab_curve(longint unsigned t);
      longint unsigned r, c;
      if (t * 1000000 > 8856 * (64'd1 << 30)) begin
         r = 0;
         for (int b = 30; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (q30_mul(q30_mul(c, c), c) <= t) r = c;
         end
         return r;
      end
      return (903292 * t + 16000 * (64'd1 << 30)) / 116000;
   endfunction

   function automatic void color_to_lab_f(logic [7:0] rc, logic [7:0] gc, logic [7:0] bc,
                                          output longint fx, output longint fy,
                                          output longint fz);
      longint unsigned r, g, b;
      r  = gamma_expand(rc);
      g  = gamma_expand(gc);
      b  = gamma_expand(bc);
      fx = lab_curve((41240 * r + 35760 * g + 18050 * b) / 95047);
      fy = lab_curve((2126 * r + 7152 * g + 722 * b) / 10000);
      fz = lab_curve((1930 * r + 11920 * g + 95050 * b) / 108883);
   endfunction

   function automatic longint unsigned scaled_mag(longint d, longint unsigned k);
      longint unsigned mag;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      return (k * mag) >> 14;
   endfunction

   function automatic logic [16:0] predict_delta_e(color_pair_type p);
      longint x1, y1, z1, x2, y2, z2;
      longint unsigned dl, da, db, n, res, bt, de;
      color_to_lab_f(p.first_red, p.first_green, p.first_blue, x1, y1, z1);
      color_to_lab_f(p.second_red, p.second_green, p.second_blue, x2, y2, z2);
      dl = scaled_mag(y1 - y2, 116);
      da = scaled_mag((x1 - y1) - (x2 - y2), 500);
      db = scaled_mag((y1 - z1) - (y2 - z2), 200);
      n   = dl * dl + da * da + db * db;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
         if (n >= res + bt) begin
            n   = n - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res >>= 1;
         end
         bt >>= 2;
      end
      de = res >> 8;
      if (de > DE_LIMIT) de = DE_LIMIT;
      return de[16:0];
   endfunction

   // ---------------- sender ---------------------------------------------------
   // Hold the pair on the bus until accepted; gaps are drawn per cycle and
   // drop valid only while idling.
   task automatic send_pair(color_pair_type p);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(p);
      exp_fifo[exp_wr] = predict_delta_e(p);
      exp_wr++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic color_pair_type random_pair(int unsigned shape);
      color_pair_type p;
      p = color_pair_type'(48'({$urandom, $urandom}));
      case (shape)
         0: begin  // near neighbors: small distances
            p.second_red   = p.first_red ^ 8'($urandom_range(3, 0));
            p.second_green = p.first_green ^ 8'($urandom_range(3, 0));
            p.second_blue  = p.first_blue ^ 8'($urandom_range(3, 0));
         end
         1: begin  // dark codes at and just above the linear gamma segment
            p.first_red   = 8'($urandom_range(12, 0));
            p.first_green = 8'($urandom_range(12, 0));
            p.second_blue = 8'($urandom_range(12, 0));
         end
         default: ;
      endcase
      return p;
   endfunction

   // Directed rows: black/white, identical colors, primaries, gamma knee codes
   // (10 and 11 straddle the linear segment) and the Lab f() knee near black.
   pair_row_type directed_rows[] = '{
      '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 17'd0},
      '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, 17'd0},
      '{'{8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77}, 1'b1, 17'd0},
      '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, 17'd0},
      '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b0, 17'd0},
      '{'{8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b0, 17'd0},
      '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, 17'd0},
      '{'{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b0, 17'd0},
      '{'{8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11}, 1'b0, 17'd0},
      '{'{8'd11, 8'd0, 8'd0, 8'd10, 8'd0, 8'd0}, 1'b0, 17'd0},
      '{'{8'd0, 8'd11, 8'd0, 8'd0, 8'd10, 8'd0}, 1'b0, 17'd0},
      '{'{8'd0, 8'd0, 8'd11, 8'd0, 8'd0, 8'd10}, 1'b0, 17'd0},
      '{'{8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0}, 1'b0, 17'd0},
      '{'{8'd24, 8'd24, 8'd24, 8'd23, 8'd23, 8'd23}, 1'b0, 17'd0},
      '{'{8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127}, 1'b0, 17'd0},
      '{'{8'd254, 8'd1, 8'd170, 8'd85, 8'd253, 8'd2}, 1'b0, 17'd0},
      '{'{8'd170, 8'd85, 8'd254, 8'd1, 8'd2, 8'd253}, 1'b0, 17'd0},
      '{'{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255}, 1'b0, 17'd0}
   };

   initial begin
      color_pair_type p;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i].pair);
         // a typed-in value must agree with the predictor as well
         if (directed_rows[i].known && exp_fifo[exp_wr-1] != directed_rows[i].de) begin
            $error("directed row %0d: delta_e expected %0d, predictor %0d",
                   i, directed_rows[i].de, exp_fifo[exp_wr-1]);
            fail_count++;
         end
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            tx_idle_pct = 86;
            rx_idle_pct = 6;
         end
         if (i == 2 * N_RANDOM / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            rx_hold     = 1'b1;   // back up the pipeline once
         end
         p = random_pair($urandom_range(3, 0));
         send_pair(p);
      end
      req_tvalid <= 1'b0;
      stim_done  <= 1'b1;
   end

   // ---------------- receiver -------------------------------------------------
   // Drive ready per cycle; on request hold it low for a long stretch.
   initial begin
      int unsigned hold_cycles;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (rx_hold && hold_cycles < 300) begin
            hold_cycles++;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
         end
      end
   end

   // Check each accepted transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (exp_rd == exp_wr) begin
            $error("unexpected result: delta_e actual %0d", rsp_tdata[16:0]);
            fail_count++;
         end else begin
            if (rsp_tdata[16:0] !== exp_fifo[exp_rd]) begin
               $error("delta_e mismatch: expected %0d, actual %0d",
                      exp_fifo[exp_rd], rsp_tdata[16:0]);
               fail_count++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:17] !== '0) begin
               $error("fill bits mismatch: expected 0, actual %0h",
                      rsp_tdata[RSP_TDATA_W-1:17]);
               fail_count++;
            end
            exp_rd++;
         end
      end
   end

   // ---------------- end of run -----------------------------------------------
   initial begin
      wait (stim_done);
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
      $display("Covered %0d color pairs (%0d results): extremes, gamma and Lab knees,",
               directed_rows.size() + N_RANDOM, rsp_count);
      $display("near and dark colors, under sender, receiver and full back-pressure.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
